/* sv/wsd_pkg.sv */
package wsd_pkg;

   // Result kinds carried on rsp_tuser.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_word_type;

endpackage

/* sv/wsd_skid.sv */
module wsd_skid
   import wsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         push_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;

   // The skid entry catches a word that arrives while the output word is stalled.
   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_word   = out_word_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

/* sv/websocket_frame_deframer.sv */
// A payload, empty-frame or error word is built from the accepted byte that causes it and
// registered in the wsd_skid output stage (or its skid entry, while the output is stalled).
// Throughput: one byte per cycle; the header parser updates its state on each accepted byte
// and a two-entry output stage keeps req_tready high while one result word is stalled.
// Reset (synchronous, active high) returns the parser to the first header byte, sets
// the length limit to 1048576 and empties the output stage.
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [23:0] csr_wdata,   // max_payload_len
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CLOSED  = 3'd6;

   localparam logic [6:0] LEN_CODE16 = 7'd126;
   localparam logic [6:0] LEN_CODE64 = 7'd127;
   localparam logic [23:0] MAX_LEN_RESET = 24'd1048576;

   logic [23:0] max_len_ff;
   logic [2:0]  phase_ff, phase_in;
   logic        mask_ff, mask_in;
   logic [23:0] len_ff, len_in;
   logic        over_ff, over_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [23:0] pos_ff, pos_in;

   logic         accept;
   logic         push;
   logic         len_done;
   logic         hdr_done;
   logic [24:0]  pos_next;
   logic [7:0]   key_byte;
   rsp_word_type push_word;
   rsp_word_type out_word;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      phase_in  = phase_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      over_in   = over_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      push_word = '0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      pos_next  = {1'b0, pos_ff} + 25'd1;
      unique case (pos_ff[1:0])
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = req_tdata[7];
               key_in  = '0;
               cnt_in  = '0;
               len_in  = '0;
               over_in = 1'b0;
               if (req_tdata[6:0] == LEN_CODE16) begin
                  phase_in = PH_EXT16;
               end else if (req_tdata[6:0] == LEN_CODE64) begin
                  phase_in = PH_EXT64;
               end else begin
                  len_in   = {17'd0, req_tdata[6:0]};
                  len_done = 1'b1;
               end
            end
            PH_EXT16: begin
               len_in = {8'd0, len_ff[7:0], req_tdata};
               if (cnt_ff >= 3'd1) begin
                  len_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_EXT64: begin
               // Bits shifted past the 24-bit window can only make the frame oversize.
               over_in = over_ff || (len_ff[23:16] != 8'd0);
               len_in  = {len_ff[15:0], req_tdata};
               if (cnt_ff >= 3'd7) begin
                  len_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], req_tdata};
               if (cnt_ff >= 3'd3) begin
                  hdr_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               push               = 1'b1;
               push_word.out_byte = req_tdata ^ key_byte;
               push_word.kind     = KIND_PAYLOAD;
               push_word.last     = (pos_next >= {1'b0, len_ff});
               pos_in             = pos_next[23:0];
               if (push_word.last) begin
                  phase_in = PH_HDR0;
                  pos_in   = '0;
               end
            end
            default: begin
            end
         endcase

         if (len_done) begin
            cnt_in = '0;
            if (mask_in) begin
               phase_in = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end

         if (hdr_done) begin
            cnt_in = '0;
            pos_in = '0;
            priority if (over_in || (len_in > max_len_ff)) begin
               phase_in       = PH_CLOSED;
               push           = 1'b1;
               push_word.kind = KIND_ERROR;
               push_word.last = 1'b1;
            end else if (len_in == 24'd0) begin
               phase_in       = PH_HDR0;
               push           = 1'b1;
               push_word.kind = KIND_EMPTY;
               push_word.last = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         phase_ff   <= PH_HDR0;
         mask_ff    <= 1'b0;
         cnt_ff     <= '0;
         over_ff    <= 1'b0;
      end else begin
         if (csr_wen) begin
            max_len_ff <= csr_wdata;
         end
         phase_ff <= phase_in;
         mask_ff  <= mask_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
      end
      len_ff <= len_in;
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   wsd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

   assign rsp_tdata = out_word.out_byte;
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;

   // A full skid entry means the output word is stalled and still valid.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("skid entry full without a valid output word");

   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLOSED) |-> !push)
      else $error("result produced after a closed connection");

   a_payload_len_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (!over_ff && (len_ff != 24'd0) && (pos_ff < len_ff)))
      else $error("payload phase with an invalid frame length");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (push && (push_word.kind == KIND_ERROR)) |=> (phase_ff == PH_CLOSED))
      else $error("error result did not close the parser");

endmodule
